FILE: rtl/ddo_pkg.sv
package ddo_pkg;

  // Fixed-point constants of the odometry datapath.
  localparam logic signed [33:0] OneQ30     = 34'sd1073741824;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [25:0]        AngleScale = 26'd44798134;
  localparam int unsigned        Micros     = 1000000;
  // Reciprocal of one million, floor(2^51 / 10^6).
  localparam logic [31:0]        MicrosRecip = 32'd2251799813;

  // Register indexes of the configuration port.
  localparam logic [0:0] RegSpeedPerRpm = 1'b0;
  localparam logic [0:0] RegInvWheelBase = 1'b1;

  // Datapath operations selected by the controller.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_WHEELS = 4'd2,
    OP_VEL    = 4'd3,
    OP_TURN   = 4'd4,
    OP_PROD   = 4'd5,
    OP_INC    = 4'd6,
    OP_HEAD   = 4'd7,
    OP_CINIT  = 4'd8,
    OP_CSTEP  = 4'd9,
    OP_CDONE  = 4'd10,
    OP_DIST   = 4'd11,
    OP_DIV    = 4'd12,
    OP_POS_X  = 4'd13,
    OP_POS_Y  = 4'd14,
    OP_QUAT   = 4'd15
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       half;
    logic [4:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  // Arctangent table in binary-angle units.
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
        5'd6: r = 32'd10680862;   5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
        5'd20: r = 32'd652;       5'd21: r = 32'd326;
        5'd22: r = 32'd163;       5'd23: r = 32'd81;
        5'd24: r = 32'd41;        5'd25: r = 32'd20;
        5'd26: r = 32'd10;        5'd27: r = 32'd5;
        5'd28: r = 32'd3;         5'd29: r = 32'd1;
        5'd30: r = 32'd1;         default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/ddo_if.sv
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] left_speed;
  logic signed [19:0] right_speed;
  logic [19:0]        elapsed_us;
  modport source (output valid, left_speed, right_speed, elapsed_us, input ready);
  modport sink (input valid, left_speed, right_speed, elapsed_us, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading;
  logic signed [31:0] body_speed;
  logic signed [31:0] turn_rate;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;
  modport source (output valid, pos_x, pos_y, heading, body_speed, turn_rate, quat_z,
                  quat_w, input ready);
  modport sink (input valid, pos_x, pos_y, heading, body_speed, turn_rate, quat_z,
                quat_w, output ready);
endinterface

interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ddo_datapath.sv
module ddo_datapath
  import ddo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic signed [19:0] left_i,
  input  logic signed [19:0] right_i,
  input  logic [19:0]        us_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [31:0] speed_o,
  output logic signed [31:0] turn_o,
  output logic signed [31:0] qz_o,
  output logic signed [31:0] qw_o
);

  localparam logic signed [63:0] I32Max = 64'sd2147483647;
  localparam logic signed [63:0] I32Min = -64'sd2147483648;

  logic [23:0] spr_q, iwb_q;
  logic signed [19:0] l_q, r_q;
  logic [19:0] us_q;
  logic signed [44:0] wl_q, wr_q;
  logic signed [31:0] speed_q, turn_q;
  logic [51:0] mag_q;
  logic neg_q;
  logic [51:0] inc_q;
  logic [31:0] head_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic cflip_q;
  logic signed [33:0] c_q, s_q;
  logic signed [52:0] num_q;
  logic [52:0] rem_q;
  logic [32:0] quo_q;
  logic [63:0] rcp_q;
  logic [52:0] qm_q;
  logic [5:0] dcnt_q;
  logic dneg_q;
  logic signed [33:0] dist_q;
  logic signed [31:0] x_q, y_q, qz_q, qw_q;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > I32Max) return 32'sh7fffffff;
    if (v < I32Min) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [33:0] clampu(input logic signed [33:0] v);
    if (v > OneQ30) return OneQ30;
    if (v < -OneQ30) return -OneQ30;
    return v;
  endfunction

  // Combinational helpers for the current operation.
  logic signed [63:0] wsum, wdiff, tprod, pprod, dprod;
  logic [31:0] cang, ca;
  logic cfl;
  logic signed [33:0] dxs, dys;
  logic [31:0] at;
  logic [25:0] hi26;
  logic [25:0] lo26;
  logic [51:0] thi;
  logic [57:0] tlo;

  always_comb begin
    wsum = 64'(wl_q) + 64'(wr_q) + 64'sd1;
    wdiff = 64'(wr_q) - 64'(wl_q);
    tprod = wdiff * $signed({1'b0, iwb_q}) + 64'sd32768;
    pprod = 64'(turn_q) * $signed({1'b0, 12'd0, us_q});
    cang = cmd_i.half ? {1'b0, head_q[31:1]} : head_q;
    cfl = cang[31] ^ cang[30];
    ca = cfl ? cang - 32'h80000000 : cang;
    dxs = cy_q >>> cmd_i.step;
    dys = cx_q >>> cmd_i.step;
    at = atan_bam(cmd_i.step);
    hi26 = mag_q[51:26];
    lo26 = mag_q[25:0];
    thi = 52'(hi26) * 52'(AngleScale);
    tlo = 58'({thi[5:0], 26'd0}) + 58'(lo26) * 58'(AngleScale) + 58'h80000000;
    dprod = 64'(speed_q) * $signed({1'b0, 12'd0, us_q}) + 64'sd500000;
  end

  logic signed [67:0] mulc;
  always_comb begin
    mulc = 68'(dist_q) * 68'(cmd_i.op == OP_POS_X ? c_q : s_q) + (68'sd1 <<< 29);
  end

  assign stat_o.div_done = (dcnt_q == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q <= 24'd58857;
      iwb_q <= 24'd327680;
      x_q <= '0;
      y_q <= '0;
      head_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegSpeedPerRpm) spr_q <= cfg_data_i;
        else iwb_q <= cfg_data_i;
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          l_q <= left_i;
          r_q <= right_i;
          us_q <= us_i;
        end
        OP_WHEELS: begin
          wl_q <= 45'((64'(l_q) * $signed({1'b0, spr_q}) + 64'sd32768) >>> 16);
          wr_q <= 45'((64'(r_q) * $signed({1'b0, spr_q}) + 64'sd32768) >>> 16);
        end
        OP_VEL: speed_q <= 32'(wsum >>> 1);
        OP_TURN: turn_q <= sat32(tprod >>> 16);
        OP_PROD: begin
          neg_q <= pprod[63];
          mag_q <= 52'(pprod[63] ? -pprod : pprod);
        end
        OP_INC: inc_q <= 52'(thi >> 6) + 52'(tlo >> 32);
        OP_HEAD: head_q <= neg_q ? head_q - inc_q[31:0] : head_q + inc_q[31:0];
        OP_CINIT: begin
          cflip_q <= cfl;
          cx_q <= CordicGain;
          cy_q <= '0;
          cz_q <= 34'($signed(ca));
        end
        OP_CSTEP: begin
          if (!cz_q[33]) begin
            cx_q <= cx_q - dxs;
            cy_q <= cy_q + dys;
            cz_q <= cz_q - 34'(at);
          end else begin
            cx_q <= cx_q + dxs;
            cy_q <= cy_q - dys;
            cz_q <= cz_q + 34'(at);
          end
        end
        OP_CDONE: begin
          c_q <= clampu(cflip_q ? -cx_q : cx_q);
          s_q <= clampu(cflip_q ? -cy_q : cy_q);
        end
        OP_DIST: begin
          dneg_q <= dprod[63];
          num_q <= 53'(dprod[63] ? -dprod + 64'(Micros - 1) : dprod);
          rem_q <= '0;
          quo_q <= '0;
          dcnt_q <= 6'd9;
        end
        OP_DIV: begin
          // Division by one million: a reciprocal multiply gives a quotient that is
          // at most four short, then compare and subtract steps fix it up.
          if (dcnt_q != 6'd0) begin
            case (dcnt_q)
              6'd9: rcp_q <= 64'(num_q[51:20]) * 64'(MicrosRecip);
              6'd8: quo_q <= 33'(rcp_q >> 31);
              6'd7: qm_q <= 53'(quo_q) * 53'(Micros);
              6'd6: rem_q <= $unsigned(num_q) - qm_q;
              default: begin
                if (rem_q >= 53'(Micros)) begin
                  rem_q <= rem_q - 53'(Micros);
                  quo_q <= quo_q + 33'd1;
                end
              end
            endcase
            dcnt_q <= dcnt_q - 6'd1;
          end
        end
        OP_POS_X: begin
          if (cmd_i.half == 1'b0) dist_q <= dneg_q ? -34'(quo_q) : 34'(quo_q);
          else x_q <= sat32(64'(x_q) + 64'(mulc >>> 30));
        end
        OP_POS_Y: y_q <= sat32(64'(y_q) + 64'(mulc >>> 30));
        OP_QUAT: begin
          qw_q <= 32'(c_q);
          qz_q <= 32'(s_q);
        end
        default: ;
      endcase
    end
  end

  assign pos_x_o = x_q;
  assign pos_y_o = y_q;
  assign heading_o = head_q;
  assign speed_o = speed_q;
  assign turn_o = turn_q;
  assign qz_o = qz_q;
  assign qw_o = qw_q;

  logic unused;
  assign unused = ^{wsum[0], tprod[15:0], inc_q[51:32], rcp_q[30:0]};

endmodule

FILE: rtl/ddo_ctrl.sv
module ddo_ctrl
  import ddo_pkg::*;
#(
  parameter int CordicSteps = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_WHEELS = 16'h0002,
    S_VEL    = 16'h0004,
    S_TURN   = 16'h0008,
    S_PROD   = 16'h0010,
    S_INC    = 16'h0020,
    S_HEAD   = 16'h0040,
    S_CINIT  = 16'h0080,
    S_CSTEP  = 16'h0100,
    S_CDONE  = 16'h0200,
    S_DIST   = 16'h0400,
    S_DIV    = 16'h0800,
    S_POSX   = 16'h1000,
    S_POSY   = 16'h2000,
    S_QUAT   = 16'h4000,
    S_OUT    = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic half_q, half_d;
  logic acc_q, acc_d;

  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_OUT) && out_ready_i);
  assign out_valid_o = (state_q == S_OUT);

  // Sequence through the datapath operations of one item.
  always_comb begin
    state_d = state_q;
    step_d = step_q;
    half_d = half_q;
    acc_d = acc_q;
    cmd_o.op = OP_NONE;
    cmd_o.half = half_q;
    cmd_o.step = step_q;
    unique case (state_q) inside
      S_IDLE, S_OUT: begin
        if (state_q == S_OUT && out_ready_i) state_d = S_IDLE;
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = OP_LOAD;
          state_d = S_WHEELS;
        end
      end
      S_WHEELS: begin cmd_o.op = OP_WHEELS; state_d = S_VEL; end
      S_VEL: begin cmd_o.op = OP_VEL; state_d = S_TURN; end
      S_TURN: begin cmd_o.op = OP_TURN; state_d = S_PROD; end
      S_PROD: begin cmd_o.op = OP_PROD; state_d = S_INC; end
      S_INC: begin cmd_o.op = OP_INC; state_d = S_HEAD; end
      S_HEAD: begin
        cmd_o.op = OP_HEAD;
        half_d = 1'b0;
        state_d = S_CINIT;
      end
      S_CINIT: begin
        cmd_o.op = OP_CINIT;
        step_d = '0;
        state_d = S_CSTEP;
      end
      S_CSTEP: begin
        cmd_o.op = OP_CSTEP;
        step_d = step_q + 5'd1;
        if (32'(step_q) == CordicSteps - 1) state_d = S_CDONE;
      end
      S_CDONE: begin
        cmd_o.op = OP_CDONE;
        state_d = half_q ? S_QUAT : S_DIST;
      end
      S_DIST: begin cmd_o.op = OP_DIST; state_d = S_DIV; end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.div_done) begin
          state_d = S_POSX;
          acc_d = 1'b0;
        end
      end
      S_POSX: begin
        cmd_o.op = OP_POS_X;
        cmd_o.half = acc_q;
        acc_d = 1'b1;
        if (acc_q) state_d = S_POSY;
      end
      S_POSY: begin
        cmd_o.op = OP_POS_Y;
        half_d = 1'b1;
        state_d = S_CINIT;
      end
      S_QUAT: begin cmd_o.op = OP_QUAT; state_d = S_OUT; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= '0;
      half_q <= 1'b0;
      acc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      half_q <= half_d;
      acc_q <= acc_d;
    end
  end

endmodule

FILE: rtl/differential_drive_odometry.sv
// Channel | Dir | Payload
// in_ch   | in  | left_speed, right_speed, elapsed_us
// out_ch  | out | pos_x, pos_y, heading, body_speed, turn_rate, quat_z, quat_w
// cfg_ch  | in  | index, data (0: speed_per_rpm, 1: inverse_wheel_base)
//
// The two CORDIC passes set most of the time that one item takes from its transfer in
// to the earliest result transfer, and the division by one million is done by
// reciprocal multiply and fix-up.
// Reset is asynchronous and clears the pose and the configuration to defaults.
// A finished result is held until taken; the next item is taken in that cycle.
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CordicSteps = 24
) (
  input logic clk_i,
  input logic rst_ni,
  ddo_in_if.sink    in_ch,
  ddo_out_if.source out_ch,
  ddo_cfg_if.sink   cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  ddo_ctrl #(.CordicSteps(CordicSteps)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .cmd_o(cmd), .stat_i(stat)
  );

  ddo_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i(cfg_ch.valid), .cfg_idx_i(cfg_ch.index), .cfg_data_i(cfg_ch.data),
    .left_i(in_ch.left_speed), .right_i(in_ch.right_speed), .us_i(in_ch.elapsed_us),
    .pos_x_o(out_ch.pos_x), .pos_y_o(out_ch.pos_y), .heading_o(out_ch.heading),
    .speed_o(out_ch.body_speed), .turn_o(out_ch.turn_rate),
    .qz_o(out_ch.quat_z), .qw_o(out_ch.quat_w)
  );

  // The w component of the quaternion stays within the unit range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.quat_w <= 32'sd1073741824 &&
                      out_ch.quat_w >= -32'sd1073741824))
    else $error("quat_w out of range");

  // No result is offered in the cycle after an item transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !out_ch.valid)
    else $error("result shown right after accept");

endmodule
